// ----- hw/rtl/pbp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and codes for the perceptron branch predictor.
// Used by the datapath and the top level; no dependencies of its own.
package pbp_pkg;

  localparam int HISTORY_LEN = 64;
  localparam int ROW_COUNT   = 1024;

  localparam int HIST_W   = $clog2(HISTORY_LEN);
  localparam int ROW_W    = $clog2(ROW_COUNT);
  localparam int ADDR_W   = ROW_W + HIST_W;
  localparam int WEIGHT_W = 9;
  localparam int THR_W    = 8;
  localparam int ADDR_IN_W = 32;
  localparam int SUM_W    = $clog2(HISTORY_LEN * ((1 << (WEIGHT_W - 1)) - 1) + 1) + 1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(137);

  typedef logic [1:0] hist_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam hist_t HIST_NONE      = 2'd0;
  localparam hist_t HIST_TAKEN     = 2'd1;
  localparam hist_t HIST_NOT_TAKEN = 2'd2;

  typedef struct packed {
    logic acc_clr;
    logic acc_en;
  } dp_ctrl_t;

  typedef struct packed {
    logic predicted;
    logic train;
  } dp_stat_t;

endpackage

// ----- hw/rtl/pbp_weight_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port weight memory: one write port and one registered read port.
// Generic; sized by its parameters only.
module pbp_weight_ram #(
  parameter int DATA_W = 9,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/pbp_datapath.sv -----
`timescale 1ns / 1ps
// Shared arithmetic unit: accumulates one weight-times-history term a cycle
// and forms the trained value of one weight. Depends on pbp_pkg.
module pbp_datapath (
  input  logic                     clk,
  input  pbp_pkg::dp_ctrl_t        ctrl,
  input  pbp_pkg::weight_t         weight,
  input  pbp_pkg::hist_t           hist,
  input  logic                     taken,
  input  logic [pbp_pkg::THR_W-1:0] thr,
  output pbp_pkg::weight_t         new_weight,
  output pbp_pkg::dp_stat_t        stat
);

  pbp_pkg::sum_t sum_r;
  pbp_pkg::sum_t sum_nxt;
  pbp_pkg::sum_t term;
  pbp_pkg::sum_t w_ext;
  pbp_pkg::sum_t mag;
  logic signed [pbp_pkg::WEIGHT_W:0] w_cmp;
  logic signed [pbp_pkg::WEIGHT_W:0] thr_pos;
  logic signed [pbp_pkg::WEIGHT_W:0] thr_neg;
  logic agree;

  assign w_ext = {{(pbp_pkg::SUM_W - pbp_pkg::WEIGHT_W){weight[pbp_pkg::WEIGHT_W-1]}}, weight};

  always_comb begin
    case (hist)
      pbp_pkg::HIST_TAKEN:     term = w_ext;
      pbp_pkg::HIST_NOT_TAKEN: term = -w_ext;
      default:                 term = '0;
    endcase
  end

  always_comb begin
    sum_nxt = sum_r;
    if (ctrl.acc_clr) begin
      sum_nxt = '0;
    end else if (ctrl.acc_en) begin
      sum_nxt = sum_r + term;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign mag = sum_r[pbp_pkg::SUM_W-1] ? -sum_r : sum_r;
  assign stat.predicted = (sum_r > 0);
  assign stat.train = (stat.predicted != taken) ||
                      (mag <= pbp_pkg::sum_t'({1'b0, thr}));

  // An empty history entry trains as not taken.
  assign agree   = ((hist == pbp_pkg::HIST_TAKEN) == taken);
  assign w_cmp   = {weight[pbp_pkg::WEIGHT_W-1], weight};
  assign thr_pos = {{(pbp_pkg::WEIGHT_W + 1 - pbp_pkg::THR_W){1'b0}}, thr};
  assign thr_neg = -thr_pos;

  always_comb begin
    new_weight = weight;
    if (agree) begin
      if (w_cmp < thr_pos) begin
        new_weight = weight + pbp_pkg::WEIGHT_W'(1);
      end
    end else begin
      if (w_cmp > thr_neg) begin
        new_weight = weight - pbp_pkg::WEIGHT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/perceptron_branch_predictor.sv -----
`timescale 1ns / 1ps
// Perceptron branch predictor top level: sequencer, history register and ports.
// A request walks its weight row once to form the sum, and once more only if it trains;
// one weight is read or read-modified-written per cycle through the single weight RAM.
// A new request is taken only once the previous one has finished.
// After reset a clearing pass writes zero to all 65536 weights, one per cycle,
// before the first request is taken; history and threshold reset at once.
module perceptron_branch_predictor (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pbp_pkg::ADDR_IN_W-1:0] in_branch_address,
  input  logic                         in_resolved_taken,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_predicted_taken,
  input  logic                         cfg_wr_en,
  input  logic [pbp_pkg::THR_W-1:0]    cfg_wr_data
);

  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_SUM       = 3'd2;
  localparam logic [2:0] S_SUM_END   = 3'd3;
  localparam logic [2:0] S_DECIDE    = 3'd4;
  localparam logic [2:0] S_TRAIN     = 3'd5;
  localparam logic [2:0] S_TRAIN_END = 3'd6;
  localparam logic [2:0] S_FINISH    = 3'd7;

  localparam logic [pbp_pkg::HIST_W-1:0] IDX_LAST = pbp_pkg::HIST_W'(pbp_pkg::HISTORY_LEN - 1);

  logic [2:0] state_r, state_nxt;
  logic [pbp_pkg::ADDR_W-1:0] clr_r, clr_nxt;
  logic [pbp_pkg::HIST_W-1:0] idx_r, idx_nxt;
  logic [pbp_pkg::ROW_W-1:0] row_r, row_nxt;
  logic taken_r, taken_nxt;
  logic pred_r, pred_nxt;
  logic rd_pend_r, rd_pend_nxt;
  pbp_pkg::hist_t hist_d_r, hist_d_nxt;
  logic [pbp_pkg::ADDR_W-1:0] addr_d_r, addr_d_nxt;
  logic [pbp_pkg::THR_W-1:0] thr_r, thr_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_pred_r, out_pred_nxt;
  pbp_pkg::hist_t hist_r [pbp_pkg::HISTORY_LEN];
  pbp_pkg::hist_t hist_nxt [pbp_pkg::HISTORY_LEN];

  logic issue;
  logic rotate;
  logic shift_in;
  logic [pbp_pkg::ADDR_W-1:0] rd_addr;
  logic wr_en;
  logic [pbp_pkg::ADDR_W-1:0] wr_addr;
  pbp_pkg::weight_t wr_data;
  pbp_pkg::weight_t rd_data;
  pbp_pkg::weight_t new_weight;
  pbp_pkg::dp_ctrl_t ctrl;
  pbp_pkg::dp_stat_t stat;
  logic out_free;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_predicted_taken = out_pred_r;
  assign out_free = !out_valid_r || !out_stall;

  assign issue    = (state_r == S_SUM) || (state_r == S_TRAIN);
  assign rotate   = issue;
  assign shift_in = (state_r == S_FINISH) && out_free;
  assign rd_addr  = {row_r, idx_r};

  assign ctrl.acc_clr = (state_r == S_IDLE);
  assign ctrl.acc_en  = rd_pend_r && ((state_r == S_SUM) || (state_r == S_SUM_END));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_d_r;
    wr_data = new_weight;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (rd_pend_r && ((state_r == S_TRAIN) || (state_r == S_TRAIN_END))) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    idx_nxt       = idx_r;
    row_nxt       = row_r;
    taken_nxt     = taken_r;
    pred_nxt      = pred_r;
    rd_pend_nxt   = issue;
    hist_d_nxt    = issue ? hist_r[0] : hist_d_r;
    addr_d_nxt    = issue ? rd_addr : addr_d_r;
    thr_nxt       = cfg_wr_en ? cfg_wr_data : thr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pred_nxt  = out_pred_r;

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + pbp_pkg::ADDR_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          row_nxt   = in_branch_address[pbp_pkg::ROW_W-1:0];
          taken_nxt = in_resolved_taken;
          idx_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        idx_nxt = idx_r + pbp_pkg::HIST_W'(1);
        if (idx_r == IDX_LAST) begin
          state_nxt = S_SUM_END;
        end
      end
      S_SUM_END: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        pred_nxt = stat.predicted;
        idx_nxt  = '0;
        state_nxt = stat.train ? S_TRAIN : S_FINISH;
      end
      S_TRAIN: begin
        idx_nxt = idx_r + pbp_pkg::HIST_W'(1);
        if (idx_r == IDX_LAST) begin
          state_nxt = S_TRAIN_END;
        end
      end
      S_TRAIN_END: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pred_nxt  = pred_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Walking the row rotates the history so that the tap at index zero always
  // holds the entry for the weight being read; a full walk restores the order.
  always_comb begin
    for (int j = 0; j < pbp_pkg::HISTORY_LEN; j++) begin
      hist_nxt[j] = hist_r[j];
    end
    if (rotate || shift_in) begin
      for (int j = 0; j < pbp_pkg::HISTORY_LEN - 1; j++) begin
        hist_nxt[j] = hist_r[j + 1];
      end
      if (shift_in) begin
        hist_nxt[pbp_pkg::HISTORY_LEN-1] =
          taken_r ? pbp_pkg::HIST_TAKEN : pbp_pkg::HIST_NOT_TAKEN;
      end else begin
        hist_nxt[pbp_pkg::HISTORY_LEN-1] = hist_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rd_pend_r   <= 1'b0;
      thr_r       <= pbp_pkg::THR_RESET;
      out_valid_r <= 1'b0;
      for (int j = 0; j < pbp_pkg::HISTORY_LEN; j++) begin
        hist_r[j] <= pbp_pkg::HIST_NONE;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
      for (int j = 0; j < pbp_pkg::HISTORY_LEN; j++) begin
        hist_r[j] <= hist_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    row_r      <= row_nxt;
    taken_r    <= taken_nxt;
    pred_r     <= pred_nxt;
    hist_d_r   <= hist_d_nxt;
    addr_d_r   <= addr_d_nxt;
    out_pred_r <= out_pred_nxt;
  end

  pbp_weight_ram #(
    .DATA_W(pbp_pkg::WEIGHT_W),
    .ADDR_W(pbp_pkg::ADDR_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  pbp_datapath u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .weight    (rd_data),
    .hist      (hist_d_r),
    .taken     (taken_r),
    .thr       (thr_r),
    .new_weight(new_weight),
    .stat      (stat)
  );

endmodule
